/* hw/rtl/efsa_pkg.sv */
// Shared types and constants for the earliest free server assignment block.
package efsa_pkg;

   localparam int SERVER_W = 5;
   localparam int SERVICE_W = 16;
   localparam int FREE_W = 32;
   localparam int MAX_SERVERS_DEFAULT = 16;
   localparam logic [SERVER_W-1:0] NUM_SERVERS_RESET = 5'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear;
      logic read;
      logic write;
   } ram_ctrl_type;

   typedef struct packed {
      logic start;
      logic sample;
   } rank_ctrl_type;

endpackage

/* hw/rtl/efsa_ram.sv */
// Server free time memory with per-entry valid bits; an entry that is not valid reads as zero.
module efsa_ram #(
   parameter int DEPTH = efsa_pkg::MAX_SERVERS_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  efsa_pkg::ram_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]           rd_addr,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [efsa_pkg::FREE_W-1:0] wr_data,
   output logic [efsa_pkg::FREE_W-1:0] rd_data
);

   logic [efsa_pkg::FREE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [efsa_pkg::FREE_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.write) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.read) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* hw/rtl/efsa_rank.sv */
// Shared compare unit that keeps the smallest and second smallest free time seen in a scan.
module efsa_rank #(
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  efsa_pkg::rank_ctrl_type     ctrl,
   input  logic [efsa_pkg::FREE_W-1:0] smp_value,
   input  logic [IDX_W-1:0]            smp_index,
   output logic [efsa_pkg::FREE_W-1:0] best_value,
   output logic [IDX_W-1:0]            best_index,
   output logic [efsa_pkg::FREE_W-1:0] second_value,
   output logic [IDX_W-1:0]            second_index,
   output logic                        second_ok
);

   logic                        have_ff, have_in;
   logic                        sec_ok_ff, sec_ok_in;
   logic [efsa_pkg::FREE_W-1:0] best_v_ff, best_v_in;
   logic [IDX_W-1:0]            best_i_ff, best_i_in;
   logic [efsa_pkg::FREE_W-1:0] sec_v_ff, sec_v_in;
   logic [IDX_W-1:0]            sec_i_ff, sec_i_in;

   // Samples arrive in rising index order, so an equal value never displaces a held one.
   always_comb begin
      have_in   = have_ff;
      sec_ok_in = sec_ok_ff;
      best_v_in = best_v_ff;
      best_i_in = best_i_ff;
      sec_v_in  = sec_v_ff;
      sec_i_in  = sec_i_ff;
      priority if (ctrl.start) begin
         have_in   = 1'b0;
         sec_ok_in = 1'b0;
      end else if (ctrl.sample && !have_ff) begin
         have_in   = 1'b1;
         best_v_in = smp_value;
         best_i_in = smp_index;
      end else if (ctrl.sample && (smp_value < best_v_ff)) begin
         sec_ok_in = 1'b1;
         sec_v_in  = best_v_ff;
         sec_i_in  = best_i_ff;
         best_v_in = smp_value;
         best_i_in = smp_index;
      end else if (ctrl.sample && (!sec_ok_ff || (smp_value < sec_v_ff))) begin
         sec_ok_in = 1'b1;
         sec_v_in  = smp_value;
         sec_i_in  = smp_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff   <= 1'b0;
         sec_ok_ff <= 1'b0;
      end else begin
         have_ff   <= have_in;
         sec_ok_ff <= sec_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      best_v_ff <= best_v_in;
      best_i_ff <= best_i_in;
      sec_v_ff  <= sec_v_in;
      sec_i_ff  <= sec_i_in;
   end

   assign best_value   = best_v_ff;
   assign best_index   = best_i_ff;
   assign second_value = sec_v_ff;
   assign second_index = sec_i_ff;
   assign second_ok    = sec_ok_ff;

endmodule

/* hw/rtl/earliest_free_server_assign.sv */
// Top level of the earliest free server assignment block.
//
// A request carries a service time and a first-of-case flag. The block
// picks the server with the smallest free time among servers 1 to
// num_servers, lowest number on ties, adds the service time to it
// (holding at the top of the 32-bit range and flagging saturation) and
// returns the assigned server and the server the next request would get.
// The first-of-case flag clears every free time before the assignment.
// num_servers is written through csr_write_en and csr_write_data; the
// user must write it only while the block is idle; the block itself
// does not enforce this. 0 acts as 1 and values above MAX_SERVERS act as
// MAX_SERVERS. For a request, the free time memory is read one server
// per cycle into a single compare unit, then the chosen server is
// updated; a new request is not accepted until that update is done.
// A response waits in an output register while rsp_stall is high; the
// update of the next request holds until that register is free.
// Reset clears all free times at once and sets num_servers to 1.
module earliest_free_server_assign #(
   parameter int MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [efsa_pkg::SERVICE_W-1:0] req_service_time,
   input  logic                           req_first_of_case,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [efsa_pkg::SERVER_W-1:0]  rsp_assigned_server,
   output logic [efsa_pkg::SERVER_W-1:0]  rsp_next_free_server,
   output logic                           rsp_saturated,
   input  logic                           csr_write_en,
   input  logic [efsa_pkg::SERVER_W-1:0]  csr_write_data
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);

   efsa_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             n_eff;
   logic [IDX_W-1:0]             rd_idx_ff;
   logic [efsa_pkg::SERVER_W-1:0] num_ff;
   logic [efsa_pkg::SERVICE_W-1:0] svc_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [efsa_pkg::SERVER_W-1:0] rsp_asg_ff;
   logic [efsa_pkg::SERVER_W-1:0] rsp_nxt_ff;
   logic                         rsp_sat_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         load_rsp;
   efsa_pkg::ram_ctrl_type       ram_ctrl;
   efsa_pkg::rank_ctrl_type      rank_ctrl;
   logic [efsa_pkg::FREE_W-1:0]  rd_data;

   logic [efsa_pkg::FREE_W-1:0]  best_value;
   logic [IDX_W-1:0]             best_index;
   logic [efsa_pkg::FREE_W-1:0]  second_value;
   logic [IDX_W-1:0]             second_index;
   logic                         second_ok;

   logic [efsa_pkg::FREE_W:0]    sum;
   logic                         sat;
   logic [efsa_pkg::FREE_W-1:0]  new_value;
   logic [IDX_W-1:0]             next_index;
   logic [IDX_W:0]               asg_num;
   logic [IDX_W:0]               nxt_num;

   always_comb begin
      priority if (num_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(num_ff) > MAX_SERVERS) begin
         n_eff = CNT_W'(MAX_SERVERS);
      end else begin
         n_eff = CNT_W'(num_ff);
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == efsa_pkg::ST_UPDATE) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         efsa_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               state_in = efsa_pkg::ST_SCAN;
            end
         end
         efsa_pkg::ST_SCAN: begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == n_eff) begin
               state_in = efsa_pkg::ST_UPDATE;
            end
         end
         efsa_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = efsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = efsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall        = 1'b1;
      ram_ctrl         = '0;
      rank_ctrl        = '0;
      unique case (state_ff)
         efsa_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            ram_ctrl.clear  = req_accept && req_first_of_case;
            rank_ctrl.start = req_accept;
         end
         efsa_pkg::ST_SCAN: begin
            ram_ctrl.read    = (cnt_ff < n_eff);
            rank_ctrl.sample = (cnt_ff != '0);
         end
         efsa_pkg::ST_UPDATE: begin
            ram_ctrl.write = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign sum       = {1'b0, best_value} + (efsa_pkg::FREE_W + 1)'(svc_ff);
   assign sat       = sum[efsa_pkg::FREE_W];
   assign new_value = sat ? '1 : sum[efsa_pkg::FREE_W-1:0];

   always_comb begin
      if (second_ok && ((second_value < new_value) ||
                        ((second_value == new_value) && (second_index < best_index)))) begin
         next_index = second_index;
      end else begin
         next_index = best_index;
      end
   end

   assign asg_num = {1'b0, best_index} + 1'b1;
   assign nxt_num = {1'b0, next_index} + 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efsa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         num_ff       <= efsa_pkg::NUM_SERVERS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            num_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[IDX_W-1:0];
      if (req_accept) begin
         svc_ff <= req_service_time;
      end
      if (load_rsp) begin
         rsp_asg_ff <= efsa_pkg::SERVER_W'(asg_num);
         rsp_nxt_ff <= efsa_pkg::SERVER_W'(nxt_num);
         rsp_sat_ff <= sat;
      end
   end

   efsa_ram #(
      .DEPTH (MAX_SERVERS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ram_ctrl),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .wr_addr (best_index),
      .wr_data (new_value),
      .rd_data (rd_data)
   );

   efsa_rank #(
      .IDX_W (IDX_W)
   ) u_rank (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (rank_ctrl),
      .smp_value    (rd_data),
      .smp_index    (rd_idx_ff),
      .best_value   (best_value),
      .best_index   (best_index),
      .second_value (second_value),
      .second_index (second_index),
      .second_ok    (second_ok)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_assigned_server  = rsp_asg_ff;
   assign rsp_next_free_server = rsp_nxt_ff;
   assign rsp_saturated        = rsp_sat_ff;

endmodule
